/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* sv/rgb2g_pkg.sv */
package rgb2g_pkg;

  localparam int WORD_W      = 32;
  localparam int GROUP_W     = 3 * WORD_W;
  localparam int PIX_W       = 24;
  localparam int GRAY_W      = 8;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CNT_W       = 11;
  localparam int SUM_W       = 10;
  localparam int MAX_ROWS    = 2048;
  localparam int MAX_WORDS   = 1536;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_FRAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_ROW = 1'b1;

  // Limits after reset: 480 rows, 640 pixels = 480 words per row
  localparam logic [CNT_W-1:0] RST_LAST_ROW  = CNT_W'(479);
  localparam logic [CNT_W-1:0] RST_LAST_WORD = CNT_W'(479);

  localparam logic [1:0] PHASE_LAST = 2'd2;
  localparam logic [1:0] PIX_LAST   = 2'd3;

  // One complete group of three words, word 0 in the low bits
  typedef struct packed {
    logic [GROUP_W-1:0] bytes;
    logic               frame_end;
  } group_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Truncated divide by three of a sum of three bytes (at most 765)
  function automatic logic [GRAY_W-1:0] div3(input logic [SUM_W-1:0] sum);
    logic [18:0] prod;
    prod = 19'(sum) * 19'd683;
    return prod[18:11];
  endfunction

  function automatic logic [CNT_W-1:0] rows_to_last(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > CFG_W'(MAX_ROWS)) begin
      res = CNT_W'(MAX_ROWS - 1);
    end else begin
      res = CNT_W'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] pixels_to_last(input logic [CFG_W-1:0] v);
    logic [CFG_W+1:0] triple;
    logic [CFG_W-1:0] words;
    logic [CNT_W-1:0] res;
    triple = {2'b00, v} + {1'b0, v, 1'b0};
    words  = triple[CFG_W+1:2];
    if (words == '0) begin
      res = '0;
    end else if (words > CFG_W'(MAX_WORDS)) begin
      res = CNT_W'(MAX_WORDS - 1);
    end else begin
      res = CNT_W'(words - 1'b1);
    end
    return res;
  endfunction

endpackage

/* sv/rgb2g_front.sv */
module rgb2g_front import rgb2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic [WORD_W-1:0]    in_word,
  input  fifo_stat_t           fifo_stat,
  output logic                 accept,
  output logic                 push,
  output group_t               push_group
);

  logic [CNT_W-1:0]  last_row_r, last_word_r;
  logic [CNT_W-1:0]  word_r, word_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [WORD_W-1:0] held_r [2];
  logic              row_done, frame_done;

  assign accept     = in_valid && !fifo_stat.full;
  assign row_done   = word_r >= last_word_r;
  assign frame_done = row_done && (row_r >= last_row_r);
  assign push       = accept && (phase_r == PHASE_LAST);

  assign push_group.bytes     = {in_word, held_r[1], held_r[0]};
  assign push_group.frame_end = frame_done;

  always_comb begin
    word_nxt  = word_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = (phase_r == PHASE_LAST) ? 2'd0 : phase_r + 2'd1;
      if (row_done) begin
        // restart the group at every row start
        word_nxt  = '0;
        phase_nxt = 2'd0;
        row_nxt   = frame_done ? '0 : row_r + 1'b1;
      end else begin
        word_nxt = word_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_row_r  <= RST_LAST_ROW;
      last_word_r <= RST_LAST_WORD;
      word_r      <= '0;
      row_r       <= '0;
      phase_r     <= 2'd0;
    end else begin
      word_r  <= word_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ROWS_IN_FRAME:  last_row_r  <= rows_to_last(cfg_data);
          REG_PIXELS_PER_ROW: last_word_r <= pixels_to_last(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase_r != PHASE_LAST)) begin
      held_r[phase_r[0]] <= in_word;
    end
  end

endmodule

/* sv/rgb2g_fifo.sv */
module rgb2g_fifo import rgb2g_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  group_t     push_group,
  input  logic       pop,
  output group_t     head,
  output fifo_stat_t stat
);

  group_t     entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head       = entry_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_group;
    end
  end

endmodule

/* sv/rgb2g_back.sv */
module rgb2g_back import rgb2g_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  group_t            head,
  input  fifo_stat_t        fifo_stat,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [GRAY_W-1:0] out_gray_value,
  output logic              out_group_end,
  output logic              out_frame_end
);

  logic [1:0]        pix_r;
  logic              valid_r, valid_nxt;
  logic [GRAY_W-1:0] gray_r;
  logic              group_end_r, frame_end_r;
  logic              load;
  logic [PIX_W-1:0]  pixel;
  logic [SUM_W-1:0]  sum;

  // advance while the queue holds a group and the output register is empty or being taken
  assign load  = !fifo_stat.empty && (!valid_r || !out_stall);
  assign pop   = load && (pix_r == PIX_LAST);
  assign pixel = head.bytes[PIX_W*pix_r +: PIX_W];
  assign sum   = SUM_W'(pixel[7:0]) + SUM_W'(pixel[15:8]) + SUM_W'(pixel[23:16]);

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pix_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      if (load) pix_r <= pix_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gray_r      <= div3(sum);
      group_end_r <= pix_r == PIX_LAST;
      frame_end_r <= (pix_r == PIX_LAST) && head.frame_end;
    end
  end

  assign out_valid      = valid_r;
  assign out_gray_value = gray_r;
  assign out_group_end  = group_end_r;
  assign out_frame_end  = frame_end_r;

endmodule

/* sv/packed_rgb_to_gray_stream.sv */
// Order: a group's third word is written into the queue, then its first gray byte into the
// output register; the other three follow one a cycle while out_stall is low.
// Throughput: one word per cycle until the two-group queue fills; sustained rate is set by
// the output register, one gray byte per cycle while out_stall is low, four bytes per three words.
// Reset (rst_n low, synchronous): counters and queue clear, limits return to 480 rows of
// 640 pixels; no clearing pass, input taken from the first cycle after reset.
module packed_rgb_to_gray_stream import rgb2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_packed_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [GRAY_W-1:0]    out_gray_value,
  output logic                 out_group_end,
  output logic                 out_frame_end
);

  fifo_stat_t fifo_stat;
  group_t     push_group, head;
  logic       push, pop, accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !accept && in_valid ? 1'b1 : fifo_stat.full;

  rgb2g_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_word    (in_packed_word),
    .fifo_stat  (fifo_stat),
    .accept     (accept),
    .push       (push),
    .push_group (push_group)
  );

  rgb2g_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  rgb2g_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .fifo_stat      (fifo_stat),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_gray_value (out_gray_value),
    .out_group_end  (out_group_end),
    .out_frame_end  (out_frame_end)
  );

endmodule

/* sv/rgb2g_checker.sv */
`include "assert_macros.svh"

module rgb2g_checker import rgb2g_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [GRAY_W-1:0] out_gray_value,
  input logic              out_group_end,
  input logic              out_frame_end
);

  // frame end only ever marks the last byte of a group
  `ASSERT_NOW(a_frame_in_group, out_valid && out_frame_end, out_group_end)

  // a group holds four bytes, so a group end is never followed at once by another
  `ASSERT_NEXT(a_group_spacing, out_valid && !out_stall && out_group_end, !out_valid || !out_group_end)

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_gray_value) && $stable(out_frame_end))

endmodule

bind packed_rgb_to_gray_stream rgb2g_checker u_rgb2g_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_gray_value (out_gray_value),
  .out_group_end  (out_group_end),
  .out_frame_end  (out_frame_end)
);

/* dv/gray_stream_checker.sv */
`timescale 1ns / 1ps

module gray_stream_checker import rgb2g_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [WORD_W-1:0]    in_packed_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [GRAY_W-1:0]    out_gray_value,
  input  logic                 out_group_end,
  input  logic                 out_frame_end,
  output int                   fail_count,
  output int                   gray_backlog
);

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              group_end;
    logic              frame_end;
  } gray_beat_t;

  gray_beat_t        gray_due[$];
  gray_beat_t        oldest;
  int                mismatches;

  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  pixels_reg;
  logic [WORD_W-1:0] held_word [2];
  logic [1:0]        word_phase;
  logic [CNT_W-1:0]  word_pos;
  logic [CNT_W-1:0]  row_pos;

  function automatic int frame_rows(input logic [CFG_W-1:0] r);
    int n;
    n = int'(r);
    if (n > MAX_ROWS) n = MAX_ROWS;
    if (n < 1) n = 1;
    return n;
  endfunction

  // Three bytes per pixel, four bytes per word
  function automatic int row_words(input logic [CFG_W-1:0] px);
    int n;
    n = (int'(px) * 3) / 4;
    if (n > MAX_WORDS) n = MAX_WORDS;
    if (n < 1) n = 1;
    return n;
  endfunction

  task automatic take_word(input logic [WORD_W-1:0] w);
    logic [GROUP_W-1:0] group;
    gray_beat_t         beat;
    int                 sum;
    int                 p;
    bit                 row_done;
    bit                 frame_done;
    row_done   = int'(word_pos) >= row_words(pixels_reg) - 1;
    frame_done = row_done && int'(row_pos) >= frame_rows(rows_reg) - 1;
    if (word_phase < PHASE_LAST) begin
      held_word[word_phase[0]] = w;
      word_phase = word_phase + 2'd1;
    end else begin
      group = {w, held_word[1], held_word[0]};
      for (p = 0; p < 4; p++) begin
        sum = int'(group[24*p +: 8]) + int'(group[24*p+8 +: 8]) + int'(group[24*p+16 +: 8]);
        beat.gray      = GRAY_W'(sum / 3);
        beat.group_end = (p == 3);
        beat.frame_end = (p == 3) && frame_done;
        gray_due.push_back(beat);
      end
      word_phase = '0;
    end
    // A partial group at the end of a row is dropped
    if (row_done) begin
      word_pos   = '0;
      word_phase = '0;
      row_pos    = frame_done ? '0 : row_pos + 1'b1;
    end else begin
      word_pos = word_pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg   = 12'd480;
      pixels_reg = 12'd640;
      word_phase = '0;
      word_pos   = '0;
      row_pos    = '0;
      gray_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (gray_due.size() == 0) begin
          $display("%0t: gray byte with none expected, actual %0d group_end %0b frame_end %0b",
                   $time, out_gray_value, out_group_end, out_frame_end);
          mismatches++;
        end else begin
          oldest = gray_due.pop_front();
          if (out_gray_value !== oldest.gray) begin
            $display("%0t: gray_value expected %0d actual %0d",
                     $time, oldest.gray, out_gray_value);
            mismatches++;
          end
          if (out_group_end !== oldest.group_end) begin
            $display("%0t: group_end expected %0b actual %0b",
                     $time, oldest.group_end, out_group_end);
            mismatches++;
          end
          if (out_frame_end !== oldest.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, oldest.frame_end, out_frame_end);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_IN_FRAME:  rows_reg   = cfg_data;
          REG_PIXELS_PER_ROW: pixels_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_word(in_packed_word);
    end
    fail_count   <= mismatches;
    gray_backlog <= gray_due.size();
  end

endmodule

/* dv/packed_rgb_to_gray_stream_test.sv */
`timescale 1ns / 1ps

module packed_rgb_to_gray_stream_test;
  import rgb2g_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 90;
  localparam int IDLE_PCT    = 22;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_packed_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [GRAY_W-1:0]    out_gray_value;
  logic                 out_group_end;
  logic                 out_frame_end;

  int   fails;
  int   gray_backlog;
  logic squeeze;
  logic calm;
  bit   squeezed;

  packed_rgb_to_gray_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packed_word (in_packed_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gray_value (out_gray_value),
    .out_group_end  (out_group_end),
    .out_frame_end  (out_frame_end)
  );

  gray_stream_checker watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packed_word (in_packed_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gray_value (out_gray_value),
    .out_group_end  (out_group_end),
    .out_frame_end  (out_frame_end),
    .fail_count     (fails),
    .gray_backlog   (gray_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none while calm
  initial begin
    out_stall <= 1'b0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeezed = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    int                b;
    w = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      for (b = 0; b < 4; b++) w[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return w;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold valid across both register writes
  task automatic program_limits(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] pixels);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROWS_IN_FRAME;
    cfg_data  <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PIXELS_PER_ROW;
    cfg_data  <= pixels;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every gray byte, then let a held word settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gray_backlog != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] pixels;
    int               n;
    int               i;
    int               ph;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_packed_word <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_ROWS_IN_FRAME;
    cfg_data       <= '0;
    squeeze        <= 1'b0;
    calm           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Byte extremes under the limits left by reset
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    send_word(32'h01FF_0102);
    drain();

    // One row of one group: every group ends the frame
    program_limits(12'd1, 12'd4);
    for (i = 0; i < 6; i++) send_word(rand_word());
    drain();

    // Zero rows and zero pixels: one-word rows, no group ever completes
    program_limits(12'd0, 12'd0);
    for (i = 0; i < 3; i++) send_word(rand_word());
    drain();

    // Six pixels per row: the trailing word of each row is dropped
    program_limits(12'd2, 12'd6);
    for (i = 0; i < 7; i++) send_word(rand_word());
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin rows = 12'd3;    pixels = 12'd8;    end
        1: begin rows = 12'd4095; pixels = 12'd4095; end
        2: begin rows = 12'd2048; pixels = 12'd2048; end
        3: begin rows = 12'd1;    pixels = 12'd1;    end
        4: begin rows = 12'd2;    pixels = 12'd10;   end
        default: begin
          rows   = CFG_W'($urandom_range(1, 5));
          pixels = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 4095))
                                              : CFG_W'(4 * $urandom_range(1, 6));
        end
      endcase
      n = (ph == 3) ? 15 : 60;
      squeeze <= (ph == 1);
      calm    <= (ph == 2);
      program_limits(rows, pixels);
      for (i = 0; i < n; i++) send_word(rand_word());
      drain();
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
